[hw/rtl/swr_pkg.sv]
`default_nettype none

package swr_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int SQUARE_W  = 31;   // a 16-bit square never exceeds 2^30
  localparam int MEAN_W    = 31;   // mean of squares never exceeds 2^30
  localparam int ROOT_W    = 16;
  localparam int LEN_W     = 9;
  localparam int LEN_RESET = 256;

  // highest power of four the root search needs for a MEAN_W-bit value
  localparam logic [MEAN_W-1:0] ROOT_BIT_INIT = MEAN_W'(1) << (2 * (ROOT_W - 1));

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_SQ,
    S_ACC,
    S_LAUNCH,
    S_CALC,
    S_OUT
  } core_state_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_ROOT
  } arith_state_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rms;
    logic              full;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/swr_fifo.sv]
`default_nettype none

module swr_fifo #(
  parameter int W = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;
  logic         do_push;
  logic         do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/swr_arith.sv]
`default_nettype none

// Serial unit: restoring divide, one quotient bit a cycle, then a
// digit-by-digit floor root, one result bit a cycle.
module swr_arith #(
  parameter int SW = 39,
  parameter int CW = 9
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [SW-1:0]             dividend,
  input  wire logic [CW-1:0]             divisor,
  output logic                           done,
  output logic [swr_pkg::ROOT_W-1:0]     root
);

  localparam int DCW = $clog2(SW);
  localparam int MW  = swr_pkg::MEAN_W;

  swr_pkg::arith_state_t state_r, state_nxt;

  logic [SW-1:0]  divq_r, divq_nxt;
  logic [CW-1:0]  rem_r, rem_nxt;
  logic [CW-1:0]  dvs_r;
  logic [DCW-1:0] div_cnt_r;
  logic [CW:0]    rem_sh;
  logic           ge;

  logic [MW-1:0]  v_r, v_nxt;
  logic [MW-1:0]  res_r, res_nxt;
  logic [MW-1:0]  bit_r;
  logic [MW-1:0]  trial;

  logic           div_step;
  logic           root_step;
  logic           last_div;
  logic           last_root;
  logic           done_r;
  logic [swr_pkg::ROOT_W-1:0] root_r;

  // divide step
  always_comb begin
    rem_sh   = {rem_r, divq_r[SW-1]};
    ge       = (rem_sh >= {1'b0, dvs_r});
    rem_nxt  = ge ? CW'(rem_sh - {1'b0, dvs_r}) : rem_sh[CW-1:0];
    divq_nxt = {divq_r[SW-2:0], ge};
  end

  // root step
  always_comb begin
    trial = res_r + bit_r;
    if (v_r >= trial) begin
      v_nxt   = v_r - trial;
      res_nxt = (res_r >> 1) + bit_r;
    end else begin
      v_nxt   = v_r;
      res_nxt = res_r >> 1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swr_pkg::A_IDLE: if (start)     state_nxt = swr_pkg::A_DIV;
      swr_pkg::A_DIV:  if (last_div)  state_nxt = swr_pkg::A_ROOT;
      swr_pkg::A_ROOT: if (last_root) state_nxt = swr_pkg::A_IDLE;
      default:                        state_nxt = swr_pkg::A_IDLE;
    endcase
  end

  always_comb begin
    div_step  = 1'b0;
    root_step = 1'b0;
    unique case (state_r)
      swr_pkg::A_DIV:  div_step  = 1'b1;
      swr_pkg::A_ROOT: root_step = 1'b1;
      default: ;
    endcase
    last_div  = div_step && (div_cnt_r == DCW'(SW - 1));
    last_root = root_step && bit_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swr_pkg::A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= last_root;
    end
  end

  always_ff @(posedge clk) begin
    if (start && state_r == swr_pkg::A_IDLE) begin
      divq_r    <= dividend;
      rem_r     <= '0;
      dvs_r     <= divisor;
      div_cnt_r <= '0;
    end else if (div_step) begin
      divq_r    <= divq_nxt;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + DCW'(1);
    end
    if (last_div) begin
      v_r   <= divq_nxt[MW-1:0];
      res_r <= '0;
      bit_r <= swr_pkg::ROOT_BIT_INIT;
    end else if (root_step) begin
      v_r   <= v_nxt;
      res_r <= res_nxt;
      bit_r <= bit_r >> 2;
    end
    if (last_root) begin
      root_r <= res_nxt[swr_pkg::ROOT_W-1:0];
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

[hw/rtl/swr_core.sv]
`default_nettype none

module swr_core #(
  parameter int MAX_WINDOW = 256,
  parameter int SLW        = 8,
  parameter int CW         = 9,
  parameter int SW         = 39
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [swr_pkg::LEN_W-1:0]          cfg_wdata,
  input  wire logic                               in_q_empty,
  input  wire logic signed [swr_pkg::SAMPLE_W-1:0] in_q_data,
  output logic                                    in_q_pop,
  input  wire logic                               res_full,
  output logic                                    res_push,
  output swr_pkg::result_t                        res_data
);

  localparam int SQW = swr_pkg::SQUARE_W;
  localparam int SMW = swr_pkg::SAMPLE_W;
  localparam logic [CW-1:0] LEN_EFF_RESET =
    (swr_pkg::LEN_RESET > MAX_WINDOW) ? CW'(MAX_WINDOW) : CW'(swr_pkg::LEN_RESET);

  swr_pkg::core_state_t state_r, state_nxt;

  logic [CW-1:0]         len_eff_r;
  logic [CW-1:0]         cfg_eff;
  logic [CW-1:0]         fill_r;
  logic [SLW-1:0]        slot_r;
  logic [SLW:0]          slot_inc;
  logic [SW-1:0]         sum_r;
  logic signed [SMW-1:0] fresh_r;
  logic signed [SMW-1:0] stale;
  logic [SMW-1:0]        rd_data_r;
  logic signed [2*SMW-1:0] prod_new;
  logic signed [2*SMW-1:0] prod_old;
  logic [SQW-1:0]        sq_new_r;
  logic [SQW-1:0]        sq_old_r;
  logic [SMW-1:0]        ring [MAX_WINDOW];

  logic                  ring_we;
  logic                  arith_start;
  logic                  arith_done;
  logic [swr_pkg::ROOT_W-1:0] arith_root;

  // zero acts as one, anything past the store size saturates
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_eff = CW'(1);
    end else if (32'(cfg_wdata) > 32'(MAX_WINDOW)) begin
      cfg_eff = CW'(MAX_WINDOW);
    end else begin
      cfg_eff = CW'(cfg_wdata);
    end
  end

  // entries not yet refilled since restart count as zero
  assign stale    = (fill_r < len_eff_r) ? '0 : $signed(rd_data_r);
  assign prod_new = fresh_r * fresh_r;
  assign prod_old = stale * stale;
  assign slot_inc = {1'b0, slot_r} + (SLW + 1)'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swr_pkg::S_IDLE:   if (!in_q_empty) state_nxt = swr_pkg::S_RD;
      swr_pkg::S_RD:     state_nxt = swr_pkg::S_SQ;
      swr_pkg::S_SQ:     state_nxt = swr_pkg::S_ACC;
      swr_pkg::S_ACC:    state_nxt = swr_pkg::S_LAUNCH;
      swr_pkg::S_LAUNCH: state_nxt = swr_pkg::S_CALC;
      swr_pkg::S_CALC:   if (arith_done) state_nxt = swr_pkg::S_OUT;
      swr_pkg::S_OUT:    if (!res_full) state_nxt = swr_pkg::S_IDLE;
      default:           state_nxt = swr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_q_pop    = 1'b0;
    ring_we     = 1'b0;
    arith_start = 1'b0;
    res_push    = 1'b0;
    unique case (state_r)
      swr_pkg::S_IDLE:   in_q_pop    = !in_q_empty;
      swr_pkg::S_ACC:    ring_we     = 1'b1;
      swr_pkg::S_LAUNCH: arith_start = 1'b1;
      swr_pkg::S_OUT:    res_push    = !res_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= swr_pkg::S_IDLE;
      len_eff_r <= LEN_EFF_RESET;
      fill_r    <= '0;
      slot_r    <= '0;
      sum_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        len_eff_r <= cfg_eff;
        fill_r    <= '0;
        slot_r    <= '0;
        sum_r     <= '0;
      end else if (ring_we) begin
        sum_r <= sum_r + SW'(sq_new_r) - SW'(sq_old_r);
        if (slot_inc == (SLW + 1)'(len_eff_r)) begin
          slot_r <= '0;
        end else begin
          slot_r <= slot_inc[SLW-1:0];
        end
        if (fill_r < len_eff_r) begin
          fill_r <= fill_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_q_pop) begin
      fresh_r <= in_q_data;
    end
    if (state_r == swr_pkg::S_SQ) begin
      sq_new_r <= prod_new[SQW-1:0];
      sq_old_r <= prod_old[SQW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[slot_r] <= fresh_r;
    end
    rd_data_r <= ring[slot_r];
  end

  swr_arith #(
    .SW(SW),
    .CW(CW)
  ) u_arith (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (arith_start),
    .dividend (sum_r),
    .divisor  (fill_r),
    .done     (arith_done),
    .root     (arith_root)
  );

  assign res_data.rms  = arith_root;
  assign res_data.full = (fill_r == len_eff_r);

endmodule

`default_nettype wire

[hw/rtl/sliding_window_rms.sv]
// Sliding-window RMS over signed 16-bit samples.
// Input queue: drive in_sample_value with in_push; a transfer happens on a
// rising edge with in_push high and in_full low. Two samples can wait.
// Result queue: while out_empty is low the oldest result sits on
// out_rms_value / out_window_full; a transfer happens on an edge with
// out_pop high. Two results can wait. Every sample yields one result:
// floor(sqrt(floor(sum of squares / fill count))) over the last window_len
// samples, and window_full once the window has filled.
// cfg_we with cfg_wdata sets window_len (0 acts as 1, values past
// MAX_WINDOW saturate) and restarts the window; write only while idle.
// The back end handles one sample at a time: read, square, accumulate, then
// the serial divider (one bit a cycle over SW bits, SW being the sum width
// 31 + log2(MAX_WINDOW)) and the 16-step root, and it takes the next sample
// only once the result has entered the result queue.
// Reset gives window_len 256 (MAX_WINDOW if smaller) and an empty window; no clearing pass is run.
// A stalled result queue holds the back end once both entries are taken,
// and the input queue then fills and raises in_full.
`default_nettype none

module sliding_window_rms #(
  parameter int MAX_WINDOW = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_push,
  input  wire logic signed [swr_pkg::SAMPLE_W-1:0] in_sample_value,
  output logic                                     in_full,
  input  wire logic                                out_pop,
  output logic [swr_pkg::ROOT_W-1:0]               out_rms_value,
  output logic                                     out_window_full,
  output logic                                     out_empty,
  input  wire logic                                cfg_we,
  input  wire logic [swr_pkg::LEN_W-1:0]           cfg_wdata
);

  localparam int SLW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW  = $clog2(MAX_WINDOW + 1);
  localparam int SW  = swr_pkg::SQUARE_W + SLW;
  localparam int RW  = $bits(swr_pkg::result_t);

  logic                                in_q_empty;
  logic                                in_q_pop;
  logic [swr_pkg::SAMPLE_W-1:0]        in_q_raw;
  logic                                res_full;
  logic                                res_push;
  swr_pkg::result_t                    res_data;
  swr_pkg::result_t                    out_data;

  swr_fifo #(
    .W(swr_pkg::SAMPLE_W)
  ) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (in_sample_value),
    .full  (in_full),
    .pop   (in_q_pop),
    .dout  (in_q_raw),
    .empty (in_q_empty)
  );

  swr_core #(
    .MAX_WINDOW (MAX_WINDOW),
    .SLW        (SLW),
    .CW         (CW),
    .SW         (SW)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_q_empty (in_q_empty),
    .in_q_data  ($signed(in_q_raw)),
    .in_q_pop   (in_q_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  swr_fifo #(
    .W(RW)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_data),
    .empty (out_empty)
  );

  assign out_rms_value   = out_data.rms;
  assign out_window_full = out_data.full;

`ifndef NO_ASSERTIONS
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result written into a full result queue");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    in_q_pop |-> !in_q_empty)
    else $error("sample taken from an empty input queue");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_q_pop |=> !res_push)
    else $error("result produced right after a sample was taken");

  a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (res_data.rms <= 16'd32768))
    else $error("root above the largest possible magnitude");
`endif

endmodule

`default_nettype wire
